### rtl/lzpf_pkg.sv
// Shared types, codes and constants for the LED zone progress-fill renderer.
`default_nettype none

package lzpf_pkg;

  // Field widths
  localparam int unsigned PosW     = 10;
  localparam int unsigned FillW    = 8;
  localparam int unsigned StartW   = 10;
  localparam int unsigned LenW     = 11;
  localparam int unsigned DirW     = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  // The reciprocal factor is floor(2^RecipShift / zone_length)
  localparam int unsigned RecipShift = 16;
  localparam int unsigned FactorW    = RecipShift + 1;
  localparam int unsigned FracShift  = 8;

  // Strip index sums: start + reversed offset can reach past 11 bits
  localparam int unsigned SumW    = 12;
  localparam int unsigned MaxLeds = 1024;

  localparam int unsigned JobDepth = 2;
  localparam int unsigned OutDepth = 2;

  typedef enum logic [CfgAddrW-1:0] {
    RegZoneStart   = 3'd0,
    RegZoneLength  = 3'd1,
    RegStripLength = 3'd2,
    RegFillDir     = 3'd3,
    RegColorMode   = 3'd4,
    RegForeRgb     = 3'd5,
    RegBackRgb     = 3'd6
  } reg_idx_e;

  typedef enum logic [DirW-1:0] {
    DirForward   = 2'd0,
    DirReverse   = 2'd1,
    DirCentreOut = 2'd2,
    DirEndsIn    = 2'd3
  } dir_e;

  typedef enum logic [ModeW-1:0] {
    ModeBoth = 2'd0,
    ModeFore = 2'd1,
    ModeBack = 2'd2
  } mode_e;

  typedef struct packed {
    logic [StartW-1:0] zone_start;
    logic [LenW-1:0]   zone_length;
    logic [LenW-1:0]   strip_length;
    logic [DirW-1:0]   fill_direction;
    logic [ModeW-1:0]  color_mode;
    logic [RgbW-1:0]   fore_rgb;
    logic [RgbW-1:0]   back_rgb;
  } cfg_t;

  // One classified position: up to two strip writes of one colour
  typedef struct packed {
    logic [IdxW-1:0] idx_first;
    logic [IdxW-1:0] idx_second;
    logic            keep_first;
    logic            keep_second;
    logic [RgbW-1:0] rgb;
  } job_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [RgbW-1:0] rgb;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

### rtl/lzpf_fifo.sv
// Small register-based first-in first-out queue.
`default_nettype none

module lzpf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/lzpf_recip.sv
// Bit-serial divider that forms floor(2^16 / zone_length), one quotient bit a cycle.
`default_nettype none

module lzpf_recip (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lzpf_pkg::LenW-1:0]   divisor_i,
  output logic                             busy_o,
  output logic [lzpf_pkg::FactorW-1:0]     factor_o
);

  import lzpf_pkg::*;

  localparam int unsigned CntW = $clog2(FactorW);

  logic               busy_q;
  logic [CntW-1:0]    cnt_q;
  logic [LenW-1:0]    div_q;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [FactorW-1:0] quo_q;
  logic [LenW:0]      rem_sh, rem_sub;
  logic               ge;

  // The dividend is a single one at bit RecipShift; shift it in MSB first
  assign rem_sh  = {rem_q, (cnt_q == CntW'(RecipShift))};
  assign ge      = (rem_sh >= {1'b0, div_q});
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign rem_d   = ge ? rem_sub[LenW-1:0] : rem_sh[LenW-1:0];

  assign busy_o   = busy_q;
  assign factor_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(RecipShift);
      div_q  <= divisor_i;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FactorW-2:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lzpf_front.sv
// Front end: takes positions, decides lit state and colour, maps to strip indices.
`default_nettype none

module lzpf_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [lzpf_pkg::PosW-1:0]   position_i,
  input  wire logic [lzpf_pkg::FillW-1:0]  fill_level_i,
  output logic                             full_o,
  input  wire logic                        busy_i,
  input  wire lzpf_pkg::cfg_t              cfg_i,
  input  wire logic [lzpf_pkg::FactorW-1:0] factor_i,
  input  wire logic                        job_full_i,
  output logic                             job_push_o,
  output lzpf_pkg::job_t                   job_o
);

  import lzpf_pkg::*;

  localparam int unsigned ProdW = PosW + FactorW;

  logic             a_valid_q;
  logic [PosW-1:0]  pos_q;
  logic [FillW-1:0] fill_q;
  logic             take;

  logic [LenW-1:0]  len;
  logic             in_zone;
  logic [ProdW-1:0] prod;
  logic [FillW-1:0] frac;
  logic             lit;
  logic             allowed;
  logic [LenW-1:0]  rev;
  logic [SumW-1:0]  start_w, pos_w, pos_half_w, rev_w, rev_half_w, len_half_w;
  logic [SumW-1:0]  idx_a, idx_b;
  logic             pair;
  logic             keep_a, keep_b;

  assign full_o = busy_i | (a_valid_q & job_full_i);
  assign take   = push_i & ~full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!a_valid_q || !job_full_i) begin
      a_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pos_q  <= position_i;
      fill_q <= fill_level_i;
    end
  end

  assign len     = cfg_i.zone_length;
  assign in_zone = (len != '0) && ({1'b0, pos_q} < len);

  assign prod = {{FactorW{1'b0}}, pos_q} * {{PosW{1'b0}}, factor_i};
  assign frac = prod[FracShift +: FillW];
  assign lit  = (fill_q != '0) && (frac <= fill_q);

  always_comb begin
    if (lit) begin
      allowed = (cfg_i.color_mode == ModeBoth) || (cfg_i.color_mode == ModeFore);
    end else begin
      allowed = (cfg_i.color_mode == ModeBoth) || (cfg_i.color_mode == ModeBack);
    end
  end

  // Offset from the far end of the zone; position is below len here
  assign rev        = len - {1'b0, pos_q} - LenW'(1);
  assign start_w    = SumW'(cfg_i.zone_start);
  assign pos_w      = SumW'(pos_q);
  assign pos_half_w = SumW'(pos_q[PosW-1:1]);
  assign rev_w      = SumW'(rev);
  assign rev_half_w = SumW'(rev[LenW-1:1]);
  assign len_half_w = SumW'(len[LenW-1:1]);

  always_comb begin
    idx_a = start_w + pos_w;
    idx_b = '0;
    pair  = 1'b0;
    case (dir_e'(cfg_i.fill_direction))
      DirForward: begin
        idx_a = start_w + pos_w;
      end
      DirReverse: begin
        idx_a = start_w + rev_w;
      end
      DirCentreOut: begin
        idx_a = start_w + rev_half_w;
        idx_b = start_w + pos_half_w + len_half_w;
        pair  = 1'b1;
      end
      DirEndsIn: begin
        idx_a = start_w + pos_half_w;
        idx_b = start_w + rev_half_w + len_half_w;
        pair  = 1'b1;
      end
      default: begin
        idx_a = start_w + pos_w;
      end
    endcase
  end

  // Drop writes past the strip end or past the addressable range
  assign keep_a = (idx_a < SumW'(cfg_i.strip_length)) && (idx_a < SumW'(MaxLeds));
  assign keep_b = pair && (idx_b < SumW'(cfg_i.strip_length)) && (idx_b < SumW'(MaxLeds));

  assign job_o.idx_first   = idx_a[IdxW-1:0];
  assign job_o.idx_second  = idx_b[IdxW-1:0];
  assign job_o.keep_first  = keep_a;
  assign job_o.keep_second = keep_b;
  assign job_o.rgb         = lit ? cfg_i.fore_rgb : cfg_i.back_rgb;

  assign job_push_o = a_valid_q & ~job_full_i & in_zone & allowed & (keep_a | keep_b);

endmodule

`default_nettype wire

### rtl/lzpf_back.sv
// Back end: expands each queued job into one or two strip writes, one beat a cycle while the output queue has room.
`default_nettype none

module lzpf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_empty_i,
  input  wire lzpf_pkg::job_t  job_i,
  output logic                 job_pop_o,
  input  wire logic            res_full_i,
  output logic                 res_push_o,
  output lzpf_pkg::res_t       res_o
);

  import lzpf_pkg::*;

  logic second_q;
  logic first_pending;

  assign first_pending = job_i.keep_first & ~second_q;

  assign res_o.index = first_pending ? job_i.idx_first : job_i.idx_second;
  assign res_o.rgb   = job_i.rgb;
  assign res_o.last  = ~(first_pending & job_i.keep_second);

  assign res_push_o = ~job_empty_i & ~res_full_i;
  assign job_pop_o  = res_push_o & res_o.last;

  // Advance to the second write once the first has left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (res_push_o) begin
      second_q <= ~res_o.last;
    end
  end

endmodule

`default_nettype wire

### rtl/led_zone_progress_fill.sv
// Top level of the LED zone progress-fill renderer.
//
//   channel   | handshake           | payload
//   ----------+---------------------+---------------------------------------------
//   positions | push_i / full_o     | position_i, fill_level_i
//   writes    | pop_i / empty_o     | write_index_o, red_o, green_o, blue_o, last_o
//   config    | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// A position is taken every cycle while the job queue has room; a position that
// makes two writes holds the back end for both, so throughput is one write a cycle
// while the output queue has room. Writes pass the position register and the job
// queue. A zone_length write keeps full_o high while the serial divider forms the
// fraction factor. Reset clears the configuration and empties both queues.
`default_nettype none

module led_zone_progress_fill #(
  parameter int unsigned JOB_DEPTH = lzpf_pkg::JobDepth,
  parameter int unsigned OUT_DEPTH = lzpf_pkg::OutDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [lzpf_pkg::PosW-1:0]     position_i,
  input  wire logic [lzpf_pkg::FillW-1:0]    fill_level_i,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic [lzpf_pkg::IdxW-1:0]          write_index_o,
  output logic [lzpf_pkg::ChanW-1:0]         red_o,
  output logic [lzpf_pkg::ChanW-1:0]         green_o,
  output logic [lzpf_pkg::ChanW-1:0]         blue_o,
  output logic                               last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lzpf_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  wire logic [lzpf_pkg::CfgDataW-1:0] cfg_wdata_i
);

  import lzpf_pkg::*;

  localparam int unsigned JobW = $bits(job_t);
  localparam int unsigned ResW = $bits(res_t);

  cfg_t               cfg_q;
  logic               recip_busy;
  logic [FactorW-1:0] factor;

  logic            job_push, job_full, job_empty, job_pop;
  job_t            job_in, job_out;
  logic [JobW-1:0] job_out_raw;

  logic            res_push, res_full;
  res_t            res_in, res_out;
  logic [ResW-1:0] res_out_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegZoneStart:   cfg_q.zone_start     <= cfg_wdata_i[StartW-1:0];
        RegZoneLength:  cfg_q.zone_length    <= cfg_wdata_i[LenW-1:0];
        RegStripLength: cfg_q.strip_length   <= cfg_wdata_i[LenW-1:0];
        RegFillDir:     cfg_q.fill_direction <= cfg_wdata_i[DirW-1:0];
        RegColorMode:   cfg_q.color_mode     <= cfg_wdata_i[ModeW-1:0];
        RegForeRgb:     cfg_q.fore_rgb       <= cfg_wdata_i[RgbW-1:0];
        RegBackRgb:     cfg_q.back_rgb       <= cfg_wdata_i[RgbW-1:0];
        default: begin
        end
      endcase
    end
  end

  lzpf_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we_i && (cfg_idx_i == RegZoneLength)),
    .divisor_i (cfg_wdata_i[LenW-1:0]),
    .busy_o    (recip_busy),
    .factor_o  (factor)
  );

  lzpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .position_i   (position_i),
    .fill_level_i (fill_level_i),
    .full_o       (full_o),
    .busy_i       (recip_busy),
    .cfg_i        (cfg_q),
    .factor_i     (factor),
    .job_full_i   (job_full),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  lzpf_fifo #(
    .Width (JobW),
    .Depth (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .empty_o (job_empty),
    .pop_i   (job_pop),
    .data_o  (job_out_raw)
  );

  assign job_out = job_t'(job_out_raw);

  lzpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  lzpf_fifo #(
    .Width (ResW),
    .Depth (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .data_o  (res_out_raw)
  );

  assign res_out       = res_t'(res_out_raw);
  assign write_index_o = res_out.index;
  assign red_o         = res_out.rgb[2*ChanW +: ChanW];
  assign green_o       = res_out.rgb[ChanW +: ChanW];
  assign blue_o        = res_out.rgb[0 +: ChanW];
  assign last_o        = res_out.last;

endmodule

`default_nettype wire

### rtl/lzpf_checker.sv
// Port-level checks on the progress-fill renderer, bound to its top level.
`default_nettype none

module lzpf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          full_o,
  input wire logic                          empty_o,
  input wire logic                          pop_i,
  input wire logic [lzpf_pkg::IdxW-1:0]     write_index_o,
  input wire logic [lzpf_pkg::ChanW-1:0]    red_o,
  input wire logic [lzpf_pkg::ChanW-1:0]    green_o,
  input wire logic [lzpf_pkg::ChanW-1:0]    blue_o,
  input wire logic                          last_o,
  input wire logic                          cfg_we_i,
  input wire logic [lzpf_pkg::CfgAddrW-1:0] cfg_idx_i
);

  import lzpf_pkg::*;

  // Nothing to pop while reset is held
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty_o)
    else $error("result queue not empty during reset");

  // A waiting write holds still until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(write_index_o) && $stable(red_o)
      && $stable(green_o) && $stable(blue_o) && $stable(last_o)))
    else $error("waiting write changed before pop");

  // The second write of a pair follows straight on from the first
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !last_o) |=> !empty_o)
    else $error("second write of a pair missing");

  // A new zone length stalls intake while its factor is formed
  a_recip_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == RegZoneLength)) |=> full_o ##15 full_o)
    else $error("positions taken while the zone factor was being formed");

endmodule

bind led_zone_progress_fill lzpf_checker u_lzpf_checker (.*);

`default_nettype wire

### dv/tb_led_zone_progress_fill.sv
// Self-checking testbench for the LED zone progress-fill renderer.
`timescale 1ns / 100ps

module tb_led_zone_progress_fill;
  import lzpf_pkg::*;

  localparam logic [ModeW-1:0] ModeNone = 2'd3;  // outside the enum: no colour allowed
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned PhaseCount    = 16;
  localparam int unsigned PhaseItems    = 125;

  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } strip_write_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                push_i       = 1'b0;
  logic [PosW-1:0]     position_i   = '0;
  logic [FillW-1:0]    fill_level_i = '0;
  logic                pop_i        = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgAddrW-1:0] cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                full_o;
  logic                empty_o;
  logic [IdxW-1:0]     write_index_o;
  logic [ChanW-1:0]    red_o;
  logic [ChanW-1:0]    green_o;
  logic [ChanW-1:0]    blue_o;
  logic                last_o;

  cfg_t         zone_cfg = '0;
  strip_write_t pending_writes[$];
  bit           idle_on = 1'b0;
  int unsigned  err_count = 0;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;

  led_zone_progress_fill u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .position_i   (position_i),
    .fill_level_i (fill_level_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .write_index_o(write_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Mostly no gap, some short ones, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Work out the strip writes one position causes under the current zone settings.
  function automatic void render_position(input logic [PosW-1:0] pos,
                                          input logic [FillW-1:0] fill);
    int unsigned  len, p, s, factor, frac, n, cnt;
    int unsigned  cand [2];
    logic         lit;
    logic [RgbW-1:0] rgb;
    strip_write_t w [2];
    len = zone_cfg.zone_length;
    p   = pos;
    s   = zone_cfg.zone_start;
    n   = 0;
    if (len == 0 || p >= len) return;
    factor = (32'd1 << RecipShift) / len;
    frac   = ((p * factor) >> FracShift) & 32'hFF;
    lit    = (fill != 0) && (frac <= fill);
    if (lit) begin
      if (zone_cfg.color_mode != ModeBoth && zone_cfg.color_mode != ModeFore) return;
      rgb = zone_cfg.fore_rgb;
    end else begin
      if (zone_cfg.color_mode != ModeBoth && zone_cfg.color_mode != ModeBack) return;
      rgb = zone_cfg.back_rgb;
    end
    cnt = 2;
    case (dir_e'(zone_cfg.fill_direction))
      DirForward: begin
        cand[0] = s + p;
        cnt = 1;
      end
      DirReverse: begin
        cand[0] = s + (len - 1 - p);
        cnt = 1;
      end
      DirCentreOut: begin
        cand[0] = s + ((len - 1 - p) >> 1);
        cand[1] = s + (p >> 1) + (len >> 1);
      end
      default: begin
        cand[0] = s + (p >> 1);
        cand[1] = s + ((len - 1 - p) >> 1) + (len >> 1);
      end
    endcase
    for (int k = 0; k < cnt; k++) begin
      // drop writes past the strip or past the addressable range
      if (cand[k] < zone_cfg.strip_length && cand[k] < MaxLeds) begin
        w[n] = '{index: cand[k][IdxW-1:0], red: rgb[23:16], green: rgb[15:8],
                 blue: rgb[7:0], last: 1'b0};
        n++;
      end
    end
    if (n != 0) w[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_writes = {pending_writes, w[k]};
  endfunction

  // Hold off until every expected write is out and the pipeline has emptied.
  task automatic wait_drained();
    push_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegZoneStart:   zone_cfg.zone_start     = data[StartW-1:0];
      RegZoneLength:  zone_cfg.zone_length    = data[LenW-1:0];
      RegStripLength: zone_cfg.strip_length   = data[LenW-1:0];
      RegFillDir:     zone_cfg.fill_direction = data[DirW-1:0];
      RegColorMode:   zone_cfg.color_mode     = data[ModeW-1:0];
      RegForeRgb:     zone_cfg.fore_rgb       = data[RgbW-1:0];
      RegBackRgb:     zone_cfg.back_rgb       = data[RgbW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_zone(input int unsigned start, input int unsigned len,
                          input int unsigned strip, input logic [DirW-1:0] dir,
                          input logic [ModeW-1:0] mode, input logic [RgbW-1:0] fore,
                          input logic [RgbW-1:0] back);
    write_reg(RegZoneStart, CfgDataW'(start));
    write_reg(RegZoneLength, CfgDataW'(len));
    write_reg(RegStripLength, CfgDataW'(strip));
    write_reg(RegFillDir, CfgDataW'(dir));
    write_reg(RegColorMode, CfgDataW'(mode));
    write_reg(RegForeRgb, fore);
    write_reg(RegBackRgb, back);
  endtask

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_position(input logic [PosW-1:0] pos, input logic [FillW-1:0] fill);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i       <= 1'b1;
    position_i   <= pos;
    fill_level_i <= fill;
    do @(posedge clk_i); while (full_o);
    render_position(pos, fill);
  endtask

  task automatic test_empty_zone();
    // registers still at reset: zone length zero
    send_position(10'd0, 8'd0);
    send_position(10'd1023, 8'd255);
    send_position(10'd5, 8'd100);
  endtask

  task automatic test_fill_extremes();
    set_zone(0, 1024, 1024, DirForward, ModeBoth, 24'hFFFFFF, 24'h000000);
    send_position(10'd0, 8'd0);
    send_position(10'd1023, 8'd255);
    send_position(10'd512, 8'd128);  // fraction equals fill: lit
    send_position(10'd516, 8'd128);  // fraction just above fill: unlit
  endtask

  task automatic test_directions();
    set_zone(3, 10, 1024, DirForward, ModeBoth, 24'h123456, 24'hA5A5A5);
    for (int k = 0; k < 4; k++) begin
      write_reg(RegFillDir, CfgDataW'(dir_e'(k)));
      send_position(PosW'(k * 3), 8'(k * 80));
    end
  endtask

  task automatic test_colour_modes();
    logic [ModeW-1:0] modes [3];
    modes = '{ModeBoth, ModeFore, ModeBack};
    set_zone(0, 4, 1024, DirForward, ModeBoth, 24'h00FF00, 24'h0000FF);
    foreach (modes[m]) begin
      write_reg(RegColorMode, CfgDataW'(modes[m]));
      send_position(10'd0, 8'd200);
      send_position(10'd3, 8'd10);
    end
    write_reg(RegColorMode, CfgDataW'(ModeNone));
    send_position(10'd0, 8'd200);
  endtask

  task automatic test_outside_zone();
    set_zone(0, 10, 1024, DirReverse, ModeBoth, 24'hFF0000, 24'h00FFFF);
    send_position(10'd10, 8'd255);
    send_position(10'd1023, 8'd0);
    write_reg(RegZoneLength, CfgDataW'(1));
    send_position(10'd0, 8'd1);
    send_position(10'd0, 8'd0);
  endtask

  task automatic test_strip_edge();
    // pair with one or both halves past the strip end
    set_zone(1000, 40, 1010, DirEndsIn, ModeBoth, 24'h808080, 24'h7F7F7F);
    send_position(10'd0, 8'd255);
    send_position(10'd30, 8'd255);
    set_zone(1023, 10, 1024, DirForward, ModeBoth, 24'h010203, 24'hFEFDFC);
    send_position(10'd5, 8'd0);
    write_reg(RegStripLength, CfgDataW'(0));
    send_position(10'd0, 8'd0);
  endtask

  task automatic test_random_phases();
    int unsigned      len, start, strip, pos, fill;
    logic [ModeW-1:0] mode;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case ($urandom_range(0, 19))
        0:       len = 0;
        1:       len = 1;
        2, 3:    len = 1024;
        4, 5:    len = $urandom_range(2, 8);
        default: len = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 5))
        0:       start = 0;
        1:       start = 1023;
        2:       start = $urandom_range(0, 1023);
        default: start = (len >= 1024) ? 0 : $urandom_range(0, 1024 - len);
      endcase
      if (start > 1023) start = 1023;
      case ($urandom_range(0, 9))
        0:       strip = 0;
        1, 2:    strip = $urandom_range(0, 1024);
        default: strip = 1024;
      endcase
      mode = ($urandom_range(0, 19) == 0) ? ModeNone : ModeW'($urandom_range(0, 2));
      set_zone(start, len, strip, DirW'($urandom_range(0, 3)), mode,
               RgbW'($urandom), RgbW'($urandom));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (PhaseItems) begin
        if (len != 0 && $urandom_range(0, 7) != 0) pos = $urandom_range(0, len - 1);
        else pos = $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
          0:       fill = 0;
          1:       fill = 255;
          default: fill = $urandom_range(0, 255);
        endcase
        send_position(pos[PosW-1:0], fill[FillW-1:0]);
      end
    end
  endtask

  // Take each write beat, compare with the oldest expectation, and pace pop.
  always @(posedge clk_i) begin
    strip_write_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (pending_writes.size() == 0) begin
          $error("unexpected write beat: write_index %0d", write_index_o);
          err_count++;
        end else begin
          want = pending_writes.pop_front();
          if (write_index_o !== want.index) begin
            $error("write_index: expected %0d, got %0d", want.index, write_index_o);
            err_count++;
          end
          if (red_o !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red_o);
            err_count++;
          end
          if (green_o !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green_o);
            err_count++;
          end
          if (blue_o !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue_o);
            err_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            err_count++;
          end
        end
      end
      if (stall_left == 0 && idle_on) stall_left = pick_gap();
      if (stall_left != 0) begin
        pop_i <= 1'b0;
        stall_left--;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Abort when no beat and no register write has happened for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_zone();
    test_fill_extremes();
    test_directions();
    test_colour_modes();
    test_outside_zone();
    test_strip_edge();
    test_random_phases();
    wait_drained();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/lzpf_pkg.sv
rtl/lzpf_fifo.sv
rtl/lzpf_recip.sv
rtl/lzpf_front.sv
rtl/lzpf_back.sv
rtl/led_zone_progress_fill.sv
rtl/lzpf_checker.sv
dv/tb_led_zone_progress_fill.sv
